// ----- hw/rtl/adq_pkg.sv -----
// Shared types and constants for the array deque block.
// Depends on nothing; every other file in hw/rtl imports it.
package adq_pkg;

  // Operation codes carried in the request's op field.
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_REAR   = 3'd3;
  localparam logic [2:0] OP_CLEAR      = 3'd4;

  // Result status codes.
  localparam logic [1:0] STS_DONE      = 2'd0;
  localparam logic [1:0] STS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STS_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data_in;
  } adq_in_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic [1:0] status;
    logic       is_empty;
    logic       front_full;
    logic       rear_full;
    logic [7:0] count;
  } adq_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // a request is taken this cycle
    logic load;    // move the finished result into the output register
  } adq_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } adq_state_t;

endpackage

// ----- hw/rtl/array_deque_core.sv -----
// Top level of the array deque: joins the controller and the datapath.
// Depends on adq_pkg, adq_ctrl and adq_datapath.
//
// Usage: each request on the in_ channel (in_valid, in_ready, in_data) asks
// for one operation: push front, push rear, pop front, pop rear or clear.
// Every request yields exactly one result on the out_ channel (out_valid,
// out_ready, out_data) carrying the popped byte, a status code, the empty
// flag, both boundary flags and the entry count after the operation.
// The entries live in a linear store of DEPTH bytes that never wraps, so a
// push at an end that reached the store boundary is refused with overflow,
// and a pop on an empty deque is refused with underflow.
// An accepted request updates the end indices, the status and the read
// register; its result is then loaded into the output register once that
// is free. A new request is taken only in the idle state, after that load.
// The result sits in an output register, so a new request is taken while
// an earlier result still waits; if the receiver stalls, that next request
// finishes execution and then waits, holding in_ready low, until the output
// register is drained.
// Reset (rst_n low, synchronous) empties the deque and homes both indices to
// DEPTH/2. The store contents are not cleared; only written slots are read.
module array_deque_core #(
  parameter int DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  adq_pkg::adq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output adq_pkg::adq_out_t out_data
);
  import adq_pkg::*;

  // Command bundle from the controller into the datapath.
  adq_cmd_t cmd;

  adq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // The datapath owns the store, both end indices and the result register.
  adq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// ----- hw/rtl/adq_ctrl.sv -----
// Controller of the array deque: request sequencing and output valid.
// Depends on adq_pkg.
module adq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output adq_pkg::adq_cmd_t cmd
);
  import adq_pkg::*;

  adq_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       load;

  // Output logic.
  always_comb begin
    in_ready = (state_r == S_IDLE);
    accept   = in_valid && (state_r == S_IDLE);
    load     = (state_r == S_EXEC) && (!out_valid_r || out_ready);
    cmd.accept = accept;
    cmd.load   = load;
    out_valid  = out_valid_r;
  end

  // Next state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    priority if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A taken request always moves on to execution.
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC))
    else $error("accepted request did not enter execution");

  // Loading a result always leaves a valid result at the output.
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r)
    else $error("loaded result not presented");

  // A result that cannot be loaded keeps the controller in execution.
  a_exec_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) && !load |=> (state_r == S_EXEC))
    else $error("result dropped while output register busy");

  // The output register is only reloaded when it is empty or being drained.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid_r || out_ready))
    else $error("pending result overwritten");

endmodule

// ----- hw/rtl/adq_datapath.sv -----
// Datapath of the array deque: slot memory, end indices and result register.
// Depends on adq_pkg.
module adq_datapath #(
  parameter int DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  adq_pkg::adq_cmd_t cmd,
  input  adq_pkg::adq_in_t  in_data,
  output adq_pkg::adq_out_t out_data
);
  import adq_pkg::*;

  localparam int IW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam logic [IW-1:0] HOME  = IW'(DEPTH / 2);
  localparam logic [IW-1:0] LIMIT = IW'(DEPTH);
  localparam logic [IW-1:0] ONE   = IW'(1);

  logic [7:0]    mem [DEPTH];
  logic [IW-1:0] front_r, front_nxt;
  logic [IW-1:0] rear_r, rear_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          pop_ok_r, pop_ok_nxt;
  logic [7:0]    rd_r;
  adq_out_t      out_r, out_nxt;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic          held;

  always_comb begin
    front_nxt  = front_r;
    rear_nxt   = rear_r;
    status_nxt = STS_DONE;
    pop_ok_nxt = 1'b0;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = front_r[AW-1:0];
    raddr      = front_r[AW-1:0];
    held       = rear_r > front_r;
    unique case (in_data.op)
      OP_PUSH_FRONT: begin
        if (front_r == '0) begin
          status_nxt = STS_OVERFLOW;
        end else begin
          front_nxt = front_r - ONE;
          waddr     = front_nxt[AW-1:0];
          we        = 1'b1;
        end
      end
      OP_PUSH_REAR: begin
        if (rear_r == LIMIT) begin
          status_nxt = STS_OVERFLOW;
        end else begin
          waddr    = rear_r[AW-1:0];
          we       = 1'b1;
          rear_nxt = rear_r + ONE;
        end
      end
      OP_POP_FRONT: begin
        if (!held) begin
          status_nxt = STS_UNDERFLOW;
        end else begin
          raddr      = front_r[AW-1:0];
          re         = 1'b1;
          pop_ok_nxt = 1'b1;
          front_nxt  = front_r + ONE;
        end
      end
      OP_POP_REAR: begin
        if (!held) begin
          status_nxt = STS_UNDERFLOW;
        end else begin
          rear_nxt   = rear_r - ONE;
          raddr      = rear_nxt[AW-1:0];
          re         = 1'b1;
          pop_ok_nxt = 1'b1;
        end
      end
      OP_CLEAR: begin
        front_nxt = HOME;
        rear_nxt  = HOME;
      end
      default: begin
      end
    endcase
  end

  // Slot memory: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.accept && we) begin
      mem[waddr] <= in_data.data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && re) begin
      rd_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= HOME;
      rear_r  <= HOME;
    end else if (cmd.accept) begin
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      status_r <= status_nxt;
      pop_ok_r <= pop_ok_nxt;
    end
  end

  always_comb begin
    out_nxt.data_out   = pop_ok_r ? rd_r : 8'd0;
    out_nxt.status     = status_r;
    out_nxt.is_empty   = (rear_r == front_r);
    out_nxt.front_full = (front_r == '0);
    out_nxt.rear_full  = (rear_r == LIMIT);
    out_nxt.count      = 8'(rear_r - front_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule
